@@ sv/alsseq_pkg.sv @@
`default_nettype none

package alsseq_pkg;

  localparam int unsigned RegW = 8;
  localparam int unsigned LedW = 5;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FLASH = 2'd1,
    CMD_HOLD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_LED3 = 2'd0,
    DIR_LED2 = 2'd1,
    DIR_NONE = 2'd2,
    DIR_RSVD = 2'd3
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UPDATE_PERIOD = 3'd0,
    REG_FLASH_STEP    = 3'd1,
    REG_FLASH_TOGGLE  = 3'd2,
    REG_ERROR_BLINK   = 3'd3,
    REG_HOLD          = 3'd4
  } reg_idx_t;

  localparam logic [RegW-1:0] UpdatePeriodRst = 8'd10;
  localparam logic [RegW-1:0] FlashStepRst    = 8'd24;
  localparam logic [RegW-1:0] FlashToggleRst  = 8'd12;
  localparam logic [RegW-1:0] ErrorBlinkRst   = 8'd25;
  localparam logic [RegW-1:0] HoldRst         = 8'd49;

  localparam int unsigned Led1Idx = 0;
  localparam int unsigned Led2Idx = 1;
  localparam int unsigned Led3Idx = 2;
  localparam int unsigned Led4Idx = 3;

  typedef struct packed {
    logic [1:0] command;
    logic       flash_dir;
    logic       standby;
    logic       heat_lock;
    logic       heat_on;
    logic       error_active;
  } in_beat_t;

  typedef struct packed {
    logic [LedW-1:0] led_pattern;
    logic            updated;
  } out_beat_t;

endpackage

`default_nettype wire

@@ sv/appliance_led_status_sequencer_unit.sv @@
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_stall    | alsseq_pkg::in_beat_t
// out_     | output    | out_valid / out_stall  | alsseq_pkg::out_beat_t
// cfg_     | input     | cfg_wr_en              | cfg_index, cfg_data
// One beat per clock while in_stall is low. State and the output register both load at the input
// accept edge; the result shows on out_ from the next cycle.
// in_stall is high only while the output register is full and stalled.
// Synchronous active-low reset restores register defaults and clears state.
`default_nettype none

module appliance_led_status_sequencer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire alsseq_pkg::in_beat_t                in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output alsseq_pkg::out_beat_t                    out_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [alsseq_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [alsseq_pkg::RegW-1:0]         cfg_data
);

  localparam int unsigned W = alsseq_pkg::RegW;

  logic [W-1:0] update_period_r, flash_step_limit_r, flash_toggle_limit_r;
  logic [W-1:0] error_blink_limit_r, hold_limit_r;

  logic [alsseq_pkg::LedW-1:0] led_r, led_nxt;
  logic [W-1:0]                div_r, div_nxt;
  logic                        flash_act_r, flash_act_nxt;
  alsseq_pkg::dir_t            flash_dir_r, flash_dir_nxt;
  logic [W-1:0]                flash_step_r, flash_step_nxt;
  logic [W-1:0]                flash_tog_r, flash_tog_nxt;
  logic                        hold_act_r, hold_act_nxt;
  logic [W-1:0]                hold_cnt_r, hold_cnt_nxt;
  logic [W-1:0]                err_cnt_r, err_cnt_nxt;
  logic                        upd_nxt;

  logic                        out_valid_r;
  alsseq_pkg::out_beat_t       out_data_r;
  logic                        in_acc;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [W:0]   n;
    logic [W:0]   t;
    logic [W-1:0] d;
    alsseq_pkg::cmd_t cmd;
    cmd            = alsseq_pkg::cmd_t'(in_data.command);
    led_nxt        = led_r;
    div_nxt        = div_r;
    flash_act_nxt  = flash_act_r;
    flash_dir_nxt  = flash_dir_r;
    flash_step_nxt = flash_step_r;
    flash_tog_nxt  = flash_tog_r;
    hold_act_nxt   = hold_act_r;
    hold_cnt_nxt   = hold_cnt_r;
    err_cnt_nxt    = err_cnt_r;
    upd_nxt        = 1'b0;
    n              = '0;
    t              = '0;
    d              = (div_r != '0) ? div_r - 1'b1 : div_r;
    case (cmd)
      alsseq_pkg::CMD_TICK: begin
        div_nxt = d;
        if (d == '0) begin
          div_nxt = update_period_r;
          upd_nxt = 1'b1;
          if (!in_data.standby) begin
            led_nxt       = '0;
            flash_act_nxt = 1'b0;
            hold_act_nxt  = 1'b0;
          end else begin
            led_nxt[alsseq_pkg::Led1Idx] = 1'b1;
            if (!in_data.heat_lock) begin
              if (in_data.heat_on) begin
                if (in_data.error_active) begin
                  if (err_cnt_r == '0) begin
                    led_nxt[alsseq_pkg::Led4Idx] = 1'b1;
                    n = (W+1)'(2);
                  end else begin
                    n = {1'b0, err_cnt_r} + 1'b1;
                  end
                  if (n > {1'b0, error_blink_limit_r}) begin
                    err_cnt_nxt = W'(1);
                    led_nxt[alsseq_pkg::Led4Idx] = ~led_nxt[alsseq_pkg::Led4Idx];
                  end else begin
                    err_cnt_nxt = n[W-1:0];
                  end
                end else begin
                  led_nxt[alsseq_pkg::Led4Idx] = 1'b1;
                end
              end else begin
                led_nxt[alsseq_pkg::Led4Idx] = 1'b0;
                err_cnt_nxt = '0;
              end
            end else begin
              err_cnt_nxt = '0;
              if (hold_act_r) begin
                led_nxt[alsseq_pkg::Led4Idx] = 1'b1;
                n = {1'b0, hold_cnt_r} + 1'b1;
                if (n > {1'b0, hold_limit_r}) begin
                  hold_cnt_nxt = '0;
                  hold_act_nxt = 1'b0;
                end else begin
                  hold_cnt_nxt = n[W-1:0];
                end
              end else begin
                hold_cnt_nxt = '0;
                led_nxt[alsseq_pkg::Led4Idx] = 1'b0;
              end
            end
            if (flash_act_r) begin
              n = {1'b0, flash_step_r} + 1'b1;
              if (n > {1'b0, flash_step_limit_r}) begin
                t = {1'b0, flash_tog_r} + 1'b1;
                flash_step_nxt = '0;
                if (t > {1'b0, flash_toggle_limit_r}) begin
                  flash_tog_nxt = '0;
                  flash_act_nxt = 1'b0;
                  flash_dir_nxt = alsseq_pkg::DIR_NONE;
                end else begin
                  flash_tog_nxt = t[W-1:0];
                  if (flash_dir_r == alsseq_pkg::DIR_LED2) begin
                    led_nxt[alsseq_pkg::Led2Idx] = ~led_nxt[alsseq_pkg::Led2Idx];
                    led_nxt[alsseq_pkg::Led3Idx] = 1'b0;
                  end else if (flash_dir_r == alsseq_pkg::DIR_LED3) begin
                    led_nxt[alsseq_pkg::Led3Idx] = ~led_nxt[alsseq_pkg::Led3Idx];
                    led_nxt[alsseq_pkg::Led2Idx] = 1'b0;
                  end
                end
              end else begin
                flash_step_nxt = n[W-1:0];
              end
            end else begin
              flash_step_nxt = '0;
              flash_tog_nxt  = '0;
              flash_dir_nxt  = alsseq_pkg::DIR_NONE;
              led_nxt[alsseq_pkg::Led2Idx] = 1'b0;
              led_nxt[alsseq_pkg::Led3Idx] = 1'b0;
            end
          end
        end
      end
      alsseq_pkg::CMD_FLASH: begin
        flash_dir_nxt = alsseq_pkg::dir_t'({1'b0, in_data.flash_dir});
        if (flash_dir_r != alsseq_pkg::dir_t'({1'b0, in_data.flash_dir}) || !flash_act_r)
        begin
          flash_step_nxt = flash_step_limit_r;
        end
        flash_act_nxt = 1'b1;
        flash_tog_nxt = '0;
      end
      alsseq_pkg::CMD_HOLD: begin
        hold_act_nxt = 1'b1;
        hold_cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      update_period_r      <= alsseq_pkg::UpdatePeriodRst;
      flash_step_limit_r   <= alsseq_pkg::FlashStepRst;
      flash_toggle_limit_r <= alsseq_pkg::FlashToggleRst;
      error_blink_limit_r  <= alsseq_pkg::ErrorBlinkRst;
      hold_limit_r         <= alsseq_pkg::HoldRst;
    end else if (cfg_wr_en) begin
      case (alsseq_pkg::reg_idx_t'(cfg_index))
        alsseq_pkg::REG_UPDATE_PERIOD: update_period_r      <= cfg_data;
        alsseq_pkg::REG_FLASH_STEP:    flash_step_limit_r   <= cfg_data;
        alsseq_pkg::REG_FLASH_TOGGLE:  flash_toggle_limit_r <= cfg_data;
        alsseq_pkg::REG_ERROR_BLINK:   error_blink_limit_r  <= cfg_data;
        alsseq_pkg::REG_HOLD:          hold_limit_r         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r        <= '0;
      div_r        <= '0;
      flash_act_r  <= 1'b0;
      flash_dir_r  <= alsseq_pkg::DIR_NONE;
      flash_step_r <= '0;
      flash_tog_r  <= '0;
      hold_act_r   <= 1'b0;
      hold_cnt_r   <= '0;
      err_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        led_r        <= led_nxt;
        div_r        <= div_nxt;
        flash_act_r  <= flash_act_nxt;
        flash_dir_r  <= flash_dir_nxt;
        flash_step_r <= flash_step_nxt;
        flash_tog_r  <= flash_tog_nxt;
        hold_act_r   <= hold_act_nxt;
        hold_cnt_r   <= hold_cnt_nxt;
        err_cnt_r    <= err_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.led_pattern <= led_nxt;
      out_data_r.updated     <= upd_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/alsseq_checker.sv @@
`default_nettype none

module alsseq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire alsseq_pkg::out_beat_t          out_data
);

  // output beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // input only stalls behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // accepted input yields an output beat next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // LED5 never driven
  a_led5_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.led_pattern[4])
    else $error("LED5 lit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind appliance_led_status_sequencer_unit alsseq_checker u_alsseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
